// ===== hdl/tfe_pkg.sv =====
package tfe_pkg;

	// Width of a position within either tag text.
	localparam int TAG_IDX_W = 4;
	localparam int TAG_SLOTS = 16;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// Start and end tag texts, padded with zero bytes past their ends.
	localparam logic [7:0] BEGIN_TAG [TAG_SLOTS] = '{
		8'h43, 8'h43, 8'h4F, 8'h56, 8'h43, 8'h4C, 8'h43, 8'h42,
		8'h45, 8'h47, 8'h49, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00
	};
	localparam logic [7:0] END_TAG [TAG_SLOTS] = '{
		8'h43, 8'h43, 8'h4F, 8'h56, 8'h43, 8'h4C, 8'h43, 8'h45,
		8'h4E, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_PASS  = 3'd1,
		MODE_MATCH = 3'd2,
		MODE_ENDED = 3'd3,
		MODE_ERROR = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_DISPATCH,
		SEQ_CMP,
		SEQ_REPLAY,
		SEQ_EMIT
	} seq_t;

	function automatic logic is_newline(input logic [7:0] b);
		return (b == CHAR_LF) || (b == CHAR_CR);
	endfunction

endpackage

// ===== hdl/tfe_in_if.sv =====
interface tfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/tfe_out_if.sv =====
interface tfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_of_run;
	logic [2:0] status;

	modport source (output valid, output out_byte, output byte_valid, output last_of_run,
		output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
		input status, output ready);
endinterface

// ===== hdl/tagged_frame_extractor_core.sv =====
// Tagged frame extractor. Serial bytes arrive one item at a time on the bytes
// channel (valid/ready). The first START_LEN bytes form a start tag; the byte
// after them is dropped and the tag is checked. A bad tag latches an error.
// After a good tag, bytes pass through on the results channel until a 'C' at
// the start of a line opens an END_LEN-byte end tag. A matching end tag ends
// the stream; a mismatch replays the gathered bytes and then the current one,
// unless that byte opens a new end tag. Every input causes one or more result
// items; the final one has last_of_run set, and status always reports the mode
// after the whole input. An ordinary byte goes from acceptance through the
// DISPATCH and EMIT states into the output register. The tag checks walk the
// tag store through one shared byte comparator in the CMP state, and an
// end-tag mismatch then replays the gathered bytes in the REPLAY state.
// Input ready is high only while the sequencer is idle. Results go through a
// single output register, so a new byte can be taken while a result waits.
// If the receiver stalls, the sequencer holds until the register drains.
// Reset (arst_n low) returns to awaiting the start tag with the flag clear.
module tagged_frame_extractor_core #(
	parameter int START_LEN = 12,
	parameter int END_LEN   = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	tfe_in_if.sink     bytes,
	tfe_out_if.source  results
);
	import tfe_pkg::*;

	localparam int STORE_DEPTH = (START_LEN > END_LEN) ? START_LEN : END_LEN;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam logic [IDX_W-1:0] START_LAST = IDX_W'(START_LEN - 1);
	localparam logic [IDX_W-1:0] END_LAST   = IDX_W'(END_LEN - 1);

	seq_t             state_q, state_d;
	mode_t            mode_q, mode_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             line_q, line_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             mism_q, mism_d;
	logic             emit_vld_q, emit_vld_d;
	logic [7:0]       byte_q, byte_d;

	// Tag store: registers, written by the sequencer at one address.
	logic [7:0]       store_q [STORE_DEPTH];
	logic             st_we;
	logic [IDX_W-1:0] st_waddr;
	logic [7:0]       st_wdata;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_bv_q;
	logic       out_last_q;
	logic [2:0] out_status_q;
	logic       out_load;
	logic [7:0] ld_byte;
	logic       ld_bv;
	logic       ld_last;

	logic             slot_free;
	logic [7:0]       rd_byte;
	logic [7:0]       tag_byte;
	logic [IDX_W-1:0] cmp_last;
	logic             mism_n;
	logic             replay_nl;
	logic             gather_after;

	assign slot_free = !out_valid_q || results.ready;
	assign rd_byte   = store_q[idx_q];
	assign cmp_last  = (mode_q == MODE_START) ? START_LAST : END_LAST;
	assign tag_byte  = (mode_q == MODE_START) ? BEGIN_TAG[TAG_IDX_W'(idx_q)]
		: END_TAG[TAG_IDX_W'(idx_q)];
	assign mism_n    = mism_q || (rd_byte != tag_byte);

	// After a replay the flag follows the last replayed byte; the current
	// byte then reopens an end tag if it is a 'C' on a fresh line.
	assign replay_nl    = is_newline(store_q[END_LAST]);
	assign gather_after = replay_nl && (byte_q == END_TAG[0]);

	assign bytes.ready = (state_q == SEQ_IDLE);

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		cnt_d      = cnt_q;
		line_d     = line_q;
		idx_d      = idx_q;
		mism_d     = mism_q;
		emit_vld_d = emit_vld_q;
		byte_d     = byte_q;
		st_we      = 1'b0;
		st_waddr   = cnt_q[IDX_W-1:0];
		st_wdata   = byte_q;
		out_load   = 1'b0;
		ld_byte    = 8'h00;
		ld_bv      = 1'b0;
		ld_last    = 1'b1;

		unique case (state_q)
			SEQ_IDLE: begin
				if (bytes.valid) begin
					byte_d  = bytes.in_byte;
					state_d = SEQ_DISPATCH;
				end
			end

			SEQ_DISPATCH: begin
				emit_vld_d = 1'b0;
				state_d    = SEQ_EMIT;
				unique case (mode_q)
					MODE_START: begin
						if (cnt_q < CNT_W'(START_LEN)) begin
							st_we = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end else begin
							idx_d   = '0;
							mism_d  = 1'b0;
							state_d = SEQ_CMP;
						end
					end
					MODE_PASS: begin
						if (is_newline(byte_q)) begin
							line_d     = 1'b1;
							emit_vld_d = 1'b1;
						end else if (line_q && (byte_q == END_TAG[0])) begin
							mode_d   = MODE_MATCH;
							line_d   = 1'b0;
							st_we    = 1'b1;
							st_waddr = '0;
							cnt_d    = CNT_W'(1);
						end else begin
							line_d     = 1'b0;
							emit_vld_d = 1'b1;
						end
					end
					MODE_MATCH: begin
						if (cnt_q < CNT_W'(END_LEN)) begin
							st_we = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end else begin
							idx_d   = '0;
							mism_d  = 1'b0;
							state_d = SEQ_CMP;
						end
					end
					default: begin
					end
				endcase
			end

			SEQ_CMP: begin
				mism_d = mism_n;
				idx_d  = idx_q + 1'b1;
				if (idx_q == cmp_last) begin
					cnt_d      = '0;
					emit_vld_d = 1'b0;
					state_d    = SEQ_EMIT;
					if (mode_q == MODE_START) begin
						mode_d = mism_n ? MODE_ERROR : MODE_PASS;
					end else if (!mism_n) begin
						mode_d = MODE_ENDED;
					end else begin
						// Settle the final mode now so the replayed items carry
						// it; the store write for a new tag waits until the end.
						mode_d     = gather_after ? MODE_MATCH : MODE_PASS;
						line_d     = is_newline(byte_q);
						cnt_d      = gather_after ? CNT_W'(1) : CNT_W'(0);
						emit_vld_d = !gather_after;
						idx_d      = '0;
						state_d    = SEQ_REPLAY;
					end
				end
			end

			SEQ_REPLAY: begin
				if (slot_free) begin
					out_load = 1'b1;
					ld_byte  = rd_byte;
					ld_bv    = 1'b1;
					ld_last  = (idx_q == END_LAST) && !emit_vld_q;
					idx_d    = idx_q + 1'b1;
					if (idx_q == END_LAST) begin
						if (emit_vld_q) begin
							state_d = SEQ_EMIT;
						end else begin
							st_we    = 1'b1;
							st_waddr = '0;
							state_d  = SEQ_IDLE;
						end
					end
				end
			end

			SEQ_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					ld_byte  = emit_vld_q ? byte_q : 8'h00;
					ld_bv    = emit_vld_q;
					state_d  = SEQ_IDLE;
				end
			end

			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			mode_q     <= MODE_START;
			cnt_q      <= '0;
			line_q     <= 1'b0;
			idx_q      <= '0;
			mism_q     <= 1'b0;
			emit_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			cnt_q      <= cnt_d;
			line_q     <= line_d;
			idx_q      <= idx_d;
			mism_q     <= mism_d;
			emit_vld_q <= emit_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		if (st_we) begin
			store_q[st_waddr] <= st_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= ld_byte;
			out_bv_q     <= ld_bv;
			out_last_q   <= ld_last;
			out_status_q <= mode_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_byte    = out_byte_q;
	assign results.byte_valid  = out_bv_q;
	assign results.last_of_run = out_last_q;
	assign results.status      = out_status_q;

endmodule
